FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, sampled on the rising clock edge.
`define ECE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ECE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/ece_pkg.sv
// ----------------------------------------------------------------------------
// ece_pkg
// Types, widths and constants of the easing curve evaluator.
// ----------------------------------------------------------------------------
package ece_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 34;              // datapath and multiplier operand width
    localparam int PW        = 2 * DW;          // full product width
    localparam int DIV_W     = 40;              // dividend width of the Newton divider
    localparam int P_W       = FRAC_BITS + 1;   // unsigned Q16 value 0..1
    localparam int IN_W      = 18;
    localparam int OUT_W     = 17;
    localparam int CFG_IW    = 3;
    localparam int CFG_DW    = 18;
    localparam int HX_W      = 17;
    localparam int HY_W      = 18;
    localparam int EL_SH     = 30 - FRAC_BITS;

    localparam longint ONE_L = longint'(1) << FRAC_BITS;

    localparam logic signed [DW-1:0]   C_ONE   = DW'(ONE_L);
    localparam logic signed [DW-1:0]   C_TOL   = DW'((ONE_L + 500000) / 1000000);
    localparam logic signed [DW-1:0]   C_K0    = DW'(((longint'(135) << FRAC_BITS) + 50) / 100);
    localparam logic signed [DW-1:0]   C_K1    = DW'(((longint'(235) << FRAC_BITS) + 50) / 100);
    localparam logic [P_W-1:0]         U_ONE   = P_W'(ONE_L);
    localparam logic [P_W-1:0]         U_HALF  = P_W'(ONE_L / 2);
    localparam logic signed [IN_W-1:0] IN_ONE  = IN_W'(ONE_L);
    localparam logic signed [HY_W-1:0] Y_MIN   = HY_W'(-(ONE_L / 2));
    localparam logic signed [HY_W-1:0] Y_MAX   = HY_W'((3 * ONE_L) / 2);

    localparam logic [29:0] Q30_QUARTER = 30'h1000_0000;
    localparam logic [29:0] Q30_HALF    = 30'h2000_0000;

    localparam logic signed [DW-1:0] C_LN2     = 34'sd744261118;
    localparam logic signed [DW-1:0] C_TWO_PI  = 34'sd6746518852;
    localparam logic signed [DW-1:0] C_SIN_TOP = 34'sd2959;

    // Taylor terms of 2^-f in Q30, lowest order first.
    localparam logic signed [DW-1:0] EXP_C [8] = '{
        34'sd1073741824, -34'sd1073741824, 34'sd536870912, -34'sd178956971,
        34'sd44739243,   -34'sd8947849,    34'sd1491308,   -34'sd213044
    };

    // Sine Horner terms in Q30, indexed by the remaining step count.
    localparam logic signed [DW-1:0] SIN_C [4] = '{
        34'sd1073741824, -34'sd178956971, 34'sd8947849, -34'sd213044
    };

    typedef enum logic [2:0] {
        MODE_LINEAR  = 3'd0,
        MODE_EASE_IN = 3'd1,
        MODE_EASE_OUT= 3'd2,
        MODE_SMOOTH  = 3'd3,
        MODE_CUBIC   = 3'd4,
        MODE_BACK    = 3'd5,
        MODE_ELASTIC = 3'd6,
        MODE_CUSTOM  = 3'd7
    } t_mode;

    typedef enum logic [CFG_IW-1:0] {
        REG_CURVE_MODE = 3'd0,
        REG_HANDLE_X1  = 3'd1,
        REG_HANDLE_Y1  = 3'd2,
        REG_HANDLE_X2  = 3'd3,
        REG_HANDLE_Y2  = 3'd4
    } t_reg_idx;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PM1,
        ST_PM2,
        ST_PM3,
        ST_EL_X,
        ST_EL_EXP,
        ST_EL_SH,
        ST_SIN_X,
        ST_SIN_X2,
        ST_SIN_POLY,
        ST_SIN_MUL,
        ST_EL_MUL,
        ST_C_START,
        ST_BZ1,
        ST_BZ2,
        ST_BZ3,
        ST_BZ4,
        ST_BZ5,
        ST_BZ6,
        ST_BZ7,
        ST_BD1,
        ST_BD2,
        ST_BD3,
        ST_BD4,
        ST_BD5,
        ST_BD6,
        ST_NEWT_E,
        ST_NEWT_D,
        ST_DIV,
        ST_NEWT_UPD,
        ST_BIS_INIT,
        ST_BIS_CHK,
        ST_Y,
        ST_Y_DONE,
        ST_DONE
    } t_state;

endpackage

FILE: design/easing_curve_evaluator_core.sv
// ----------------------------------------------------------------------------
// easing_curve_evaluator_core
// Maps a Q16 progress word to the eased Q16 value of the selected curve.
// ----------------------------------------------------------------------------
// One word is processed at a time on a single shared 34 x 34 multiplier with a
// rounding shifter, plus a 40-bit restoring divider for the Newton quotient.
// The custom Bezier curve dominates: each Newton step evaluates x(t) and
// x'(t) and runs the divider, each bisection step evaluates x(t), and a final
// y(t) evaluation follows. A new word can be taken in the cycle after the
// previous result is in the output register, which may still be waiting to be
// taken.
module easing_curve_evaluator_core #(
    parameter int NEWTON_STEPS = 8,
    parameter int BISECT_STEPS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ece_pkg::CFG_IW-1:0]         i_cfg_index,
    input  logic [ece_pkg::CFG_DW-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [ece_pkg::IN_W-1:0]    i_progress_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ece_pkg::OUT_W-1:0]          o_eased_out
);
    import ece_pkg::*;

    localparam int ITER_MAX = (NEWTON_STEPS > BISECT_STEPS) ? NEWTON_STEPS : BISECT_STEPS;
    localparam int IW       = $clog2(ITER_MAX + 1);
    localparam int CW       = $clog2(DIV_W);

    // Control and configuration
    t_state r_state, n_state, r_ret, n_ret;
    t_mode  r_mode;
    logic [HX_W-1:0]        r_hx1, r_hx2;
    logic signed [HY_W-1:0] r_hy1, r_hy2;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out;

    // Datapath
    logic [P_W-1:0]         r_p, r_t, r_lo, r_hi, n_p, n_t, n_lo, n_hi;
    logic signed [DW-1:0]   r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_x, r_d, r_res;
    logic signed [DW-1:0]   n_v0, n_v1, n_v2, n_v3, n_v4, n_v5, n_x, n_d, n_res;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [IW-1:0]          r_iter, n_iter;
    logic                   r_bez_y, n_bez_y, r_neg, n_neg, r_qneg, n_qneg;
    logic [DW:0]            r_rem, n_rem;
    logic [DIV_W-1:0]       r_quo, n_quo;

    // Shared multiplier
    logic signed [DW-1:0] mul_a, mul_b, mul_res;
    logic [5:0]           mul_sh;
    logic signed [PW-1:0] mul_prod, mul_half, mul_rnd;

    // Derived values
    logic [P_W-1:0]        p_in, x1c, x2c;
    logic signed [HY_W-1:0] y1c, y2c;
    logic signed [DW-1:0]  p_s, t_s, it_s, ha, hb, g_s, e_s, e_abs, d_abs, bx_diff;
    logic                  out_free, low_half, p_end;
    logic [P_W+EL_SH-1:0]  el_p30;
    logic signed [DW-1:0]  el_e30;
    logic [29:0]           el_u, el_ph0, el_ph;
    logic [DW:0]           div_sh, div_dif;
    logic [DIV_W:0]        nt_sum, nt_dif, q_ext, t_ext;
    logic [P_W-1:0]        nt_val, bis_lo, bis_hi, bis_mid;
    logic [P_W:0]          bis_sum;

    // ------------------------------------------------------------------
    // Operand preparation
    // ------------------------------------------------------------------
    always_comb begin
        if (i_progress_in < 0) begin
            p_in = '0;
        end else if (i_progress_in > IN_ONE) begin
            p_in = U_ONE;
        end else begin
            p_in = i_progress_in[P_W-1:0];
        end
    end

    assign x1c = (r_hx1 > U_ONE) ? U_ONE : r_hx1;
    assign x2c = (r_hx2 > U_ONE) ? U_ONE : r_hx2;
    assign y1c = (r_hy1 < Y_MIN) ? Y_MIN : ((r_hy1 > Y_MAX) ? Y_MAX : r_hy1);
    assign y2c = (r_hy2 < Y_MIN) ? Y_MIN : ((r_hy2 > Y_MAX) ? Y_MAX : r_hy2);

    assign p_s      = DW'(r_p);
    assign t_s      = DW'(r_t);
    assign it_s     = C_ONE - t_s;
    assign ha       = r_bez_y ? DW'(y1c) : DW'(x1c);
    assign hb       = r_bez_y ? DW'(y2c) : DW'(x2c);
    assign low_half = (r_p < U_HALF);
    assign g_s      = low_half ? p_s : ((C_ONE - p_s) <<< 1);
    assign p_end    = (r_p == '0) || (r_p == U_ONE);

    assign e_s     = r_x - p_s;
    assign e_abs   = (e_s < 0) ? -e_s : e_s;
    assign d_abs   = (r_d < 0) ? -r_d : r_d;
    assign bx_diff = e_s;

    // Elastic phase terms
    assign el_p30 = {r_p, EL_SH'(0)};
    assign el_e30 = (DW'(el_p30) <<< 3) + DW'(el_p30);
    assign el_u   = 30'((32'(el_p30) << 1) + 32'(el_p30) - 32'(Q30_QUARTER));
    assign el_ph0 = {1'b0, el_u[28:0]};
    assign el_ph  = (el_ph0 > Q30_QUARTER) ? (Q30_HALF - el_ph0) : el_ph0;

    // Divider step
    assign div_sh  = {r_rem[DW-1:0], r_quo[DIV_W-1]};
    assign div_dif = div_sh - {1'b0, d_abs};

    // Newton update of t with saturation
    assign q_ext  = {1'b0, r_quo};
    assign t_ext  = (DIV_W+1)'(r_t);
    assign nt_sum = t_ext + q_ext;
    assign nt_dif = t_ext - q_ext;
    always_comb begin
        if (r_qneg) begin
            nt_val = (nt_sum > (DIV_W+1)'(U_ONE)) ? U_ONE : nt_sum[P_W-1:0];
        end else begin
            nt_val = (q_ext > t_ext) ? '0 : nt_dif[P_W-1:0];
        end
    end

    // Bisection bracket update
    assign bis_lo  = (r_x < p_s) ? r_t : r_lo;
    assign bis_hi  = (r_x < p_s) ? r_hi : r_t;
    assign bis_sum = {1'b0, bis_lo} + {1'b0, bis_hi};
    assign bis_mid = bis_sum[P_W:1];

    // ------------------------------------------------------------------
    // Shared multiplier with round-half-up shift
    // ------------------------------------------------------------------
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_sh = 6'(FRAC_BITS);
        unique case (r_state)
            ST_PM1: begin
                unique case (r_mode)
                    MODE_EASE_OUT: begin
                        mul_a = C_ONE - p_s;
                        mul_b = C_ONE - p_s;
                    end
                    MODE_CUBIC: begin
                        mul_a = g_s;
                        mul_b = g_s;
                    end
                    MODE_BACK: begin
                        mul_a = p_s - C_ONE;
                        mul_b = p_s - C_ONE;
                    end
                    default: begin
                        mul_a = p_s;
                        mul_b = p_s;
                    end
                endcase
            end
            ST_PM2: begin
                unique case (r_mode)
                    MODE_SMOOTH: begin
                        mul_a = r_v0;
                        mul_b = (C_ONE * 3) - (p_s <<< 1);
                    end
                    MODE_BACK: begin
                        mul_a = C_K1;
                        mul_b = p_s - C_ONE;
                    end
                    default: begin
                        mul_a = r_v0;
                        mul_b = g_s;
                    end
                endcase
            end
            ST_PM3: begin
                mul_a = r_v0;
                mul_b = r_v1 + C_K0;
            end
            ST_EL_X: begin
                mul_a  = DW'(el_e30[29:0]);
                mul_b  = C_LN2;
                mul_sh = 6'd30;
            end
            ST_EL_EXP: begin
                mul_a  = r_v1;
                mul_b  = r_v0;
                mul_sh = 6'd30;
            end
            ST_EL_SH: begin
                mul_a  = r_v1;
                mul_b  = DW'(1);
                mul_sh = 6'(el_e30[DW-1:30]);
            end
            ST_SIN_X: begin
                mul_a  = DW'(el_ph);
                mul_b  = C_TWO_PI;
                mul_sh = 6'd30;
            end
            ST_SIN_X2: begin
                mul_a  = r_v3;
                mul_b  = r_v3;
                mul_sh = 6'd30;
            end
            ST_SIN_POLY: begin
                mul_a  = r_v5;
                mul_b  = r_v4;
                mul_sh = 6'd30;
            end
            ST_SIN_MUL: begin
                mul_a  = r_v5;
                mul_b  = r_v3;
                mul_sh = 6'd30;
            end
            ST_EL_MUL: begin
                mul_a  = r_v2;
                mul_b  = r_neg ? -r_v5 : r_v5;
                mul_sh = 6'(60 - FRAC_BITS);
            end
            ST_BZ1, ST_BD5: begin
                mul_a = t_s;
                mul_b = t_s;
            end
            ST_BZ2, ST_BD1: begin
                mul_a = it_s;
                mul_b = it_s;
            end
            ST_BZ3: begin
                mul_a = r_v1;
                mul_b = t_s;
            end
            ST_BZ4: begin
                mul_a = r_v2;
                mul_b = ha;
            end
            ST_BZ5: begin
                mul_a = it_s;
                mul_b = r_v0;
            end
            ST_BZ6: begin
                mul_a = r_v3;
                mul_b = hb;
            end
            ST_BZ7: begin
                mul_a = r_v0;
                mul_b = t_s;
            end
            ST_BD2: begin
                mul_a = r_v0;
                mul_b = ha;
            end
            ST_BD3: begin
                mul_a = it_s;
                mul_b = t_s;
            end
            ST_BD4: begin
                mul_a = r_v1;
                mul_b = hb - ha;
            end
            ST_BD6: begin
                mul_a = r_v2;
                mul_b = C_ONE - hb;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;
    assign mul_half = (mul_sh == 6'd0) ? '0 : (PW'(1) <<< (mul_sh - 6'd1));
    assign mul_rnd  = (mul_prod + mul_half) >>> mul_sh;
    assign mul_res  = mul_rnd[DW-1:0];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_SETUP;
            ST_SETUP: begin
                unique case (r_mode)
                    MODE_LINEAR:  n_state = ST_DONE;
                    MODE_BACK:    n_state = p_end ? ST_DONE : ST_PM1;
                    MODE_ELASTIC: n_state = p_end ? ST_DONE : ST_EL_X;
                    MODE_CUSTOM:  n_state = ST_C_START;
                    default:      n_state = ST_PM1;
                endcase
            end
            ST_PM1: begin
                if (r_mode == MODE_EASE_IN || r_mode == MODE_EASE_OUT) n_state = ST_DONE;
                else n_state = ST_PM2;
            end
            ST_PM2:      n_state = (r_mode == MODE_BACK) ? ST_PM3 : ST_DONE;
            ST_PM3:      n_state = ST_DONE;
            ST_EL_X:     n_state = ST_EL_EXP;
            ST_EL_EXP:   if (r_cnt == '0) n_state = ST_EL_SH;
            ST_EL_SH:    n_state = ST_SIN_X;
            ST_SIN_X:    n_state = ST_SIN_X2;
            ST_SIN_X2:   n_state = ST_SIN_POLY;
            ST_SIN_POLY: if (r_cnt == '0) n_state = ST_SIN_MUL;
            ST_SIN_MUL:  n_state = ST_EL_MUL;
            ST_EL_MUL:   n_state = ST_DONE;
            ST_C_START:  n_state = p_end ? ST_Y : ST_BZ1;
            ST_BZ1:      n_state = ST_BZ2;
            ST_BZ2:      n_state = ST_BZ3;
            ST_BZ3:      n_state = ST_BZ4;
            ST_BZ4:      n_state = ST_BZ5;
            ST_BZ5:      n_state = ST_BZ6;
            ST_BZ6:      n_state = ST_BZ7;
            ST_BZ7:      n_state = r_ret;
            ST_BD1:      n_state = ST_BD2;
            ST_BD2:      n_state = ST_BD3;
            ST_BD3:      n_state = ST_BD4;
            ST_BD4:      n_state = ST_BD5;
            ST_BD5:      n_state = ST_BD6;
            ST_BD6:      n_state = ST_NEWT_D;
            ST_NEWT_E:   n_state = (e_abs <= C_TOL) ? ST_Y : ST_BD1;
            ST_NEWT_D:   n_state = (d_abs <= C_TOL) ? ST_BIS_INIT : ST_DIV;
            ST_DIV:      if (r_cnt == CW'(DIV_W - 1)) n_state = ST_NEWT_UPD;
            ST_NEWT_UPD: begin
                n_state = (r_iter == IW'(NEWTON_STEPS - 1)) ? ST_BIS_INIT : ST_BZ1;
            end
            ST_BIS_INIT: n_state = ST_BZ1;
            ST_BIS_CHK: begin
                if (e_abs <= C_TOL || r_iter == IW'(BISECT_STEPS - 1)) n_state = ST_Y;
                else n_state = ST_BZ1;
            end
            ST_Y:        n_state = ST_BZ1;
            ST_Y_DONE:   n_state = ST_DONE;
            ST_DONE:     if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        n_p = r_p;   n_t = r_t;   n_lo = r_lo;  n_hi = r_hi;
        n_v0 = r_v0; n_v1 = r_v1; n_v2 = r_v2;  n_v3 = r_v3;
        n_v4 = r_v4; n_v5 = r_v5; n_x = r_x;    n_d = r_d;
        n_res = r_res;
        n_cnt = r_cnt; n_iter = r_iter; n_bez_y = r_bez_y; n_neg = r_neg;
        n_qneg = r_qneg; n_rem = r_rem; n_quo = r_quo; n_ret = r_ret;
        unique case (r_state)
            ST_IDLE:  n_p = p_in;
            ST_SETUP: n_res = p_s;
            ST_PM1: begin
                unique case (r_mode)
                    MODE_EASE_IN:  n_res = mul_res;
                    MODE_EASE_OUT: n_res = C_ONE - mul_res;
                    default:       n_v0  = mul_res;
                endcase
            end
            ST_PM2: begin
                unique case (r_mode)
                    MODE_SMOOTH: n_res = mul_res;
                    MODE_BACK:   n_v1  = mul_res;
                    default: begin
                        if (low_half) n_res = mul_res <<< 2;
                        else n_res = C_ONE - ((mul_res + DW'(1)) >>> 1);
                    end
                endcase
            end
            ST_PM3: n_res = C_ONE + mul_res;
            ST_EL_X: begin
                n_v0  = mul_res;
                n_v1  = EXP_C[7];
                n_cnt = CW'(6);
            end
            ST_EL_EXP: begin
                n_v1 = mul_res + EXP_C[r_cnt[2:0]];
                if (r_cnt != '0) n_cnt = r_cnt - CW'(1);
            end
            ST_EL_SH: n_v2 = mul_res;
            ST_SIN_X: begin
                n_v3  = mul_res;
                n_v5  = C_SIN_TOP;
                n_neg = el_u[29];
                n_cnt = CW'(3);
            end
            ST_SIN_X2: n_v4 = mul_res;
            ST_SIN_POLY: begin
                n_v5 = mul_res + SIN_C[r_cnt[1:0]];
                if (r_cnt != '0) n_cnt = r_cnt - CW'(1);
            end
            ST_SIN_MUL: n_v5 = mul_res;
            ST_EL_MUL:  n_res = C_ONE + mul_res;
            ST_C_START: begin
                n_t     = r_p;
                n_iter  = '0;
                n_bez_y = 1'b0;
                n_ret   = ST_NEWT_E;
            end
            ST_BZ1: n_v0 = mul_res;
            ST_BZ2: n_v1 = mul_res;
            ST_BZ3: n_v2 = mul_res;
            ST_BZ4: n_v2 = mul_res;
            ST_BZ5: n_v3 = mul_res;
            ST_BZ6: n_v3 = mul_res;
            ST_BZ7: n_x  = (r_v2 * 3) + (r_v3 * 3) + mul_res;
            ST_BD1: n_v0 = mul_res;
            ST_BD2: n_v0 = mul_res;
            ST_BD3: n_v1 = mul_res;
            ST_BD4: n_v1 = mul_res;
            ST_BD5: n_v2 = mul_res;
            ST_BD6: n_d  = (r_v0 * 3) + (r_v1 * 6) + (mul_res * 3);
            ST_NEWT_D: begin
                // The quotient magnitude is built first and signed afterwards.
                n_rem  = '0;
                n_quo  = {e_abs[DIV_W-FRAC_BITS-1:0], FRAC_BITS'(0)};
                n_qneg = (e_s < 0) ^ (r_d < 0);
                n_cnt  = '0;
            end
            ST_DIV: begin
                if (!div_dif[DW]) begin
                    n_rem = div_dif;
                    n_quo = {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    n_rem = div_sh;
                    n_quo = {r_quo[DIV_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + CW'(1);
            end
            ST_NEWT_UPD: begin
                n_t    = nt_val;
                n_iter = r_iter + IW'(1);
            end
            ST_BIS_INIT: begin
                n_t    = r_p;
                n_lo   = '0;
                n_hi   = U_ONE;
                n_iter = '0;
                n_ret  = ST_BIS_CHK;
            end
            ST_BIS_CHK: begin
                if (bx_diff < -C_TOL || bx_diff > C_TOL) begin
                    n_lo   = bis_lo;
                    n_hi   = bis_hi;
                    n_t    = bis_mid;
                    n_iter = r_iter + IW'(1);
                end
            end
            ST_Y: begin
                if (r_mode == MODE_CUSTOM && r_p == U_ONE && r_ret == ST_NEWT_E) n_t = U_ONE;
                else if (r_p == '0 && r_ret == ST_NEWT_E) n_t = '0;
                n_bez_y = 1'b1;
                n_ret   = ST_Y_DONE;
            end
            ST_Y_DONE: n_res = r_x;
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_out_valid = r_out_valid;
        o_eased_out = r_out;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_NEWT_E;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_LINEAR;
            r_hx1       <= HX_W'(27525);
            r_hy1       <= HY_W'(0);
            r_hx2       <= HX_W'(38011);
            r_hy2       <= HY_W'(65536);
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_CURVE_MODE: r_mode <= t_mode'(i_cfg_data[2:0]);
                    REG_HANDLE_X1:  r_hx1  <= i_cfg_data[HX_W-1:0];
                    REG_HANDLE_Y1:  r_hy1  <= i_cfg_data[HY_W-1:0];
                    REG_HANDLE_X2:  r_hx2  <= i_cfg_data[HX_W-1:0];
                    REG_HANDLE_Y2:  r_hy2  <= i_cfg_data[HY_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;   r_t <= n_t;   r_lo <= n_lo; r_hi <= n_hi;
        r_v0 <= n_v0; r_v1 <= n_v1; r_v2 <= n_v2; r_v3 <= n_v3;
        r_v4 <= n_v4; r_v5 <= n_v5; r_x <= n_x;   r_d <= n_d;
        r_res <= n_res;
        r_cnt <= n_cnt; r_iter <= n_iter; r_bez_y <= n_bez_y;
        r_neg <= n_neg; r_qneg <= n_qneg; r_rem <= n_rem; r_quo <= n_quo;
        if (r_state == ST_DONE && out_free) begin
            if (r_res < 0) begin
                r_out <= '0;
            end else if (r_res > C_ONE) begin
                r_out <= OUT_W'(ONE_L);
            end else begin
                r_out <= r_res[OUT_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    `ECE_ASSERT_IMPL(a_out_in_range, o_out_valid, o_eased_out <= U_ONE, "eased word above one")
    `ECE_ASSERT_IMPL(a_div_nonzero, r_state == ST_DIV, r_d != '0, "divider entered with zero slope")
    `ECE_ASSERT(a_hold_result, (r_state == ST_DONE && r_out_valid && !i_out_ready) |=> (r_state == ST_DONE), "result dropped while output busy")
    `ECE_ASSERT_IMPL(a_t_in_range, r_state == ST_BZ1, r_t <= U_ONE, "solver parameter outside unit range")

endmodule

FILE: tb/easing_curve_checker.sv
// ----------------------------------------------------------------------------
// easing_curve_checker
// Watches the progress and eased-value channels and the register writes,
// predicts each eased value in fixed point and compares it with the block.
// ----------------------------------------------------------------------------
module easing_curve_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ece_pkg::CFG_IW-1:0]      i_cfg_index,
    input  logic [ece_pkg::CFG_DW-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic signed [ece_pkg::IN_W-1:0] i_progress_in,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [ece_pkg::OUT_W-1:0]       i_eased_out,
    output int                              o_errors,
    output int                              o_pending
);
    import ece_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NEWTON_ITERS = 8;
    localparam int BISECT_ITERS = 12;
    localparam longint UNIT     = ONE_L;
    localparam longint TOLER    = (UNIT + 500000) / 1000000;
    localparam longint Q30_ONE  = longint'(1) << 30;

    t_mode                   mode_q;
    logic [HX_W-1:0]         hx1_q, hx2_q;
    logic signed [HY_W-1:0]  hy1_q, hy2_q;
    logic [OUT_W-1:0]        eased_q[$];

    // Round half up by an arithmetic right shift; exact for negatives.
    function automatic longint round_shift(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_shift(a * b, FRAC_BITS);
    endfunction

    function automatic longint q30mul(longint a, longint b);
        return round_shift(a * b, 30);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint curve_at(longint t, longint a, longint b);
        longint it, t2, i2;
        it = UNIT - t;
        t2 = qmul(t, t);
        i2 = qmul(it, it);
        return 3 * qmul(qmul(i2, t), a) + 3 * qmul(qmul(it, t2), b) + qmul(t2, t);
    endfunction

    function automatic longint slope_at(longint t, longint a, longint b);
        longint it;
        it = UNIT - t;
        return 3 * qmul(qmul(it, it), a) + 6 * qmul(qmul(it, t), b - a)
             + 3 * qmul(qmul(t, t), UNIT - b);
    endfunction

    function automatic longint find_param(longint p, longint x1, longint x2);
        longint t, lo, hi, err, der, x;
        t = p;
        lo = 0;
        hi = UNIT;
        if (p <= 0) return 0;
        if (p >= UNIT) return UNIT;
        for (int i = 0; i < NEWTON_ITERS; i++) begin
            err = curve_at(t, x1, x2) - p;
            if (mag(err) <= TOLER) return t;
            der = slope_at(t, x1, x2);
            if (mag(der) <= TOLER) break;
            t = clip(t - (err * UNIT) / der, 0, UNIT);
        end
        t = p;
        for (int i = 0; i < BISECT_ITERS; i++) begin
            x = curve_at(t, x1, x2);
            if (mag(x - p) <= TOLER) break;
            if (x < p) lo = t;
            else hi = t;
            t = (lo + hi) >>> 1;
        end
        return clip(t, 0, UNIT);
    endfunction

    function automatic longint exp2_frac(longint f30);
        longint coef[8];
        longint x, acc;
        coef = '{1073741824, -1073741824, 536870912, -178956971,
                 44739243, -8947849, 1491308, -213044};
        x = q30mul(f30, 744261118);
        acc = coef[7];
        for (int k = 6; k >= 0; k--) acc = q30mul(acc, x) + coef[k];
        return acc;
    endfunction

    function automatic longint sine_turn(longint ph);
        longint x, x2, acc;
        bit neg;
        neg = 0;
        if (ph >= (Q30_ONE >> 1)) begin
            neg = 1;
            ph -= Q30_ONE >> 1;
        end
        if (ph > (Q30_ONE >> 2)) ph = (Q30_ONE >> 1) - ph;
        x = q30mul(ph, 64'sd6746518852);
        x2 = q30mul(x, x);
        acc = 2959;
        acc = q30mul(acc, x2) - 213044;
        acc = q30mul(acc, x2) + 8947849;
        acc = q30mul(acc, x2) - 178956971;
        acc = q30mul(acc, x2) + 1073741824;
        acc = q30mul(acc, x);
        return neg ? -acc : acc;
    endfunction

    function automatic longint elastic_at(longint p);
        longint p30, e30, ex, ph;
        int n;
        p30 = p <<< (30 - FRAC_BITS);
        e30 = 9 * p30;
        n = int'(e30 >>> 30);
        ex = round_shift(exp2_frac(e30 & (Q30_ONE - 1)), n);
        ph = (3 * p30 - (Q30_ONE >> 2)) & (Q30_ONE - 1);
        return UNIT + round_shift(ex * sine_turn(ph), 60 - FRAC_BITS);
    endfunction

    function automatic logic [OUT_W-1:0] eased_value(logic signed [IN_W-1:0] raw);
        longint p, r, q, k0, k1, s, x1, x2, y1, y2;
        p = clip(longint'(raw), 0, UNIT);
        r = p;
        case (mode_q)
            MODE_EASE_IN:  r = qmul(p, p);
            MODE_EASE_OUT: begin
                q = UNIT - p;
                r = UNIT - qmul(q, q);
            end
            MODE_SMOOTH:   r = qmul(qmul(p, p), 3 * UNIT - 2 * p);
            MODE_CUBIC: begin
                if (p < UNIT / 2) begin
                    r = 4 * qmul(qmul(p, p), p);
                end else begin
                    q = 2 * UNIT - 2 * p;
                    r = UNIT - round_shift(qmul(qmul(q, q), q), 1);
                end
            end
            MODE_BACK: begin
                if (p != 0 && p != UNIT) begin
                    k0 = ((longint'(135) << FRAC_BITS) + 50) / 100;
                    k1 = ((longint'(235) << FRAC_BITS) + 50) / 100;
                    s = p - UNIT;
                    r = UNIT + qmul(qmul(s, s), qmul(k1, s) + k0);
                end
            end
            MODE_ELASTIC: if (p != 0 && p != UNIT) r = elastic_at(p);
            MODE_CUSTOM: begin
                x1 = clip(longint'(hx1_q), 0, UNIT);
                x2 = clip(longint'(hx2_q), 0, UNIT);
                y1 = clip(longint'(hy1_q), -UNIT / 2, 3 * UNIT / 2);
                y2 = clip(longint'(hy2_q), -UNIT / 2, 3 * UNIT / 2);
                r = curve_at(find_param(p, x1, x2), y1, y2);
            end
            default: r = p;
        endcase
        return OUT_W'(clip(r, 0, UNIT));
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = eased_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q <= MODE_LINEAR;
            hx1_q  <= HX_W'(27525);
            hy1_q  <= '0;
            hx2_q  <= HX_W'(38011);
            hy2_q  <= HY_W'(65536);
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_CURVE_MODE: mode_q <= t_mode'(i_cfg_data[2:0]);
                    REG_HANDLE_X1:  hx1_q  <= i_cfg_data[HX_W-1:0];
                    REG_HANDLE_Y1:  hy1_q  <= i_cfg_data;
                    REG_HANDLE_X2:  hx2_q  <= i_cfg_data[HX_W-1:0];
                    REG_HANDLE_Y2:  hy2_q  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) eased_q.push_back(eased_value(i_progress_in));
            if (i_out_valid && i_out_ready) begin
                if (eased_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %0d", i_eased_out));
                end else begin
                    if (i_eased_out !== eased_q[0])
                        report_mismatch($sformatf("eased_out %0d, predicted %0d",
                                                  i_eased_out, eased_q[0]));
                    void'(eased_q.pop_front());
                end
            end
        end
    end
endmodule

FILE: tb/tb_easing_curve_evaluator_core.sv
// ----------------------------------------------------------------------------
// tb_easing_curve_evaluator_core
// Drives progress words through every curve and several handle settings, with
// bursty input and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_easing_curve_evaluator_core;
    import ece_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic                     i_clk = 0;
    logic                     i_rst_n = 0;
    logic                     i_cfg_we = 0;
    logic [CFG_IW-1:0]        i_cfg_index = '0;
    logic [CFG_DW-1:0]        i_cfg_data = '0;
    logic                     i_in_valid = 0;
    logic                     o_in_ready;
    logic signed [IN_W-1:0]   i_progress_in = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 0;
    logic [OUT_W-1:0]         o_eased_out;
    int                       errors, pending;
    int                       idle_cycles = 0;
    bit                       stall_free = 0;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    easing_curve_evaluator_core dut (.*);

    easing_curve_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_progress_in,
        .i_out_valid(o_out_valid), .i_out_ready, .i_eased_out(o_eased_out),
        .o_errors(errors), .o_pending(pending)
    );

    // The receiver stalls at random; some phases leave it always ready.
    always @(posedge i_clk) begin
        if (stall_free) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 7) == 0);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [CFG_DW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Valid stays high after the accepting edge; the caller either sends the
    // next word at once or drops valid before any gap.
    task automatic send_progress(logic signed [IN_W-1:0] v);
        i_in_valid    <= 1'b1;
        i_progress_in <= v;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    function automatic logic signed [IN_W-1:0] pick_progress();
        case ($urandom_range(0, 9))
            0:       return IN_W'($urandom);
            1:       return IN_ONE + IN_W'($urandom_range(0, 3));
            2:       return IN_W'($urandom_range(0, 3));
            default: return IN_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic random_burst(int n);
        int left;
        int gap;
        left = n;
        while (left > 0) begin
            for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--) begin
                send_progress(pick_progress());
                left--;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0 || left == 0) i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        logic signed [IN_W-1:0] edges[12];
        edges = '{18'sh20000, 18'sh1FFFF, -18'sd1, 18'sd0, 18'sd1, 18'sd32767,
                  18'sd32768, 18'sd32769, 18'sd65535, 18'sd65536, 18'sd65537,
                  18'sh1FFFF};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every curve at the extremes and around the midpoint.
        for (int m = 0; m < 8; m++) begin
            write_reg(REG_CURVE_MODE, CFG_DW'(m));
            foreach (edges[k]) if (m == 7 || k % 2 == 0 || k > 5) send_progress(edges[k]);
            i_in_valid <= 1'b0;
            drain();
        end

        // Out-of-range handles and flat Bezier sections, then random sets.
        for (int ph = 0; ph < 8; ph++) begin
            stall_free = (ph % 3 == 0);
            case (ph)
                0: begin
                    write_reg(REG_HANDLE_X1, 18'h1FFFF);
                    write_reg(REG_HANDLE_Y1, 18'h20000);
                    write_reg(REG_HANDLE_X2, 18'h00000);
                    write_reg(REG_HANDLE_Y2, 18'h1FFFF);
                end
                1: begin
                    write_reg(REG_HANDLE_X1, 18'd0);
                    write_reg(REG_HANDLE_Y1, CFG_DW'(Y_MIN));
                    write_reg(REG_HANDLE_X2, 18'd65536);
                    write_reg(REG_HANDLE_Y2, CFG_DW'(Y_MAX));
                end
                default: begin
                    write_reg(REG_HANDLE_X1, CFG_DW'($urandom_range(0, 65536)));
                    write_reg(REG_HANDLE_Y1, CFG_DW'($urandom_range(0, 131072) - 32768));
                    write_reg(REG_HANDLE_X2, CFG_DW'($urandom_range(0, 65536)));
                    write_reg(REG_HANDLE_Y2, CFG_DW'($urandom_range(0, 131072) - 32768));
                end
            endcase
            write_reg(REG_CURVE_MODE, CFG_DW'(MODE_CUSTOM));
            random_burst(30);
            drain();
        end

        // Random curves, with the mode changed between phases.
        for (int ph = 0; ph < 16; ph++) begin
            stall_free = (ph % 4 == 1);
            write_reg(REG_CURVE_MODE, CFG_DW'($urandom_range(0, 7)));
            random_burst(30);
            drain();
        end

        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+design
design/ece_pkg.sv
design/easing_curve_evaluator_core.sv
tb/easing_curve_checker.sv
tb/tb_easing_curve_evaluator_core.sv
